[hw/rtl/otn_pkg.sv]
// Package with the word types, sizes and controller states of the triangle normal block.
`timescale 1ns / 1ps
package otn_pkg;

   localparam int PointSlots = 4096;
   localparam int AddrBits   = $clog2(PointSlots);

   typedef struct packed {
      logic               action;
      logic [11:0]        point_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [11:0]        vertex_a;
      logic [11:0]        vertex_b;
      logic [11:0]        vertex_c;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] face_x;
      logic signed [15:0] face_y;
      logic signed [15:0] face_z;
      logic               reversed;
      logic               degenerate;
   } rsp_word_type;

   localparam logic ActStore    = 1'b0;
   localparam logic ActTriangle = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_FETCH  = 8'b0000_0010,
      ST_CROSS  = 8'b0000_0100,
      ST_DOT    = 8'b0000_1000,
      ST_NORM   = 8'b0001_0000,
      ST_SQUARE = 8'b0010_0000,
      ST_SQRT   = 8'b0100_0000,
      ST_DIVIDE = 8'b1000_0000
   } state_type;

endpackage

[hw/rtl/oriented_triangle_normal_top.sv]
// Top level of the triangle normal block: vertex store, digit-serial arithmetic and controller.
//
//   channel   ports                   direction  transfer
//   request   start, busy, req_word   in         start high while busy low
//   response  rsp_valid, rsp_word     out        one-cycle strobe, no back pressure
//
// A store word writes the vertex store and leaves the block idle. A triangle word first
// does the three vertex reads, then one radix-16 multiply-accumulate unit runs the six
// cross products, the dot sign and the squared length, a one-bit shifter normalizes, a
// bit-pair square root follows and a restoring divider gives the three outputs. If all
// cross products are zero, the word ends after them with the degenerate flag set. Reset
// is synchronous and clears the controller; the store holds no reset value.
`timescale 1ns / 1ps
module oriented_triangle_normal_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  otn_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output otn_pkg::rsp_word_type rsp_word
);

   logic [31:0] mem_x [otn_pkg::PointSlots];
   logic [31:0] mem_y [otn_pkg::PointSlots];
   logic [31:0] mem_z [otn_pkg::PointSlots];
   logic [47:0] mem_n [otn_pkg::PointSlots];

   otn_pkg::state_type state_ff, state_in;
   logic [1:0]  fc_ff, fc_in;
   logic [11:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in, idx_c_ff, idx_c_in;
   logic [11:0] rd_idx;
   logic        rd_ok_ff;
   logic [31:0] rdx_ff, rdy_ff, rdz_ff;
   logic [47:0] rdn_ff;
   logic signed [31:0] dpos [3];
   logic signed [15:0] dnrm [3];
   logic signed [31:0] pa_ff [3], pa_in [3];
   logic signed [32:0] e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [17:0] ns_ff [3], ns_in [3];
   logic [87:0] acc_ff, acc_in, mc_ff, mc_in, acc_sum;
   logic [35:0] mp_ff, mp_in;
   logic [4:0]  dig_ff, dig_in, dig_last;
   logic [2:0]  prod_ff, prod_in;
   logic signed [67:0] c_ff [3], c_in [3];
   logic [66:0] mg_ff [3], mg_in [3];
   logic        rev_ff, rev_in;
   logic [63:0] sq_s_ff, sq_s_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in, sq_t;
   logic [31:0] len_ff, len_in;
   logic [46:0] rem_ff, rem_in, ds_ff, ds_in;
   logic [15:0] q_ff, q_in, face_val;
   logic        rsp_valid_ff, rsp_valid_in;
   otn_pkg::rsp_word_type rsp_ff, rsp_in;
   logic [87:0] ld_a;
   logic signed [33:0] ld_b, ld_bmag;
   logic        ld_sub, ld_neg, any_hi, any_29, all_zero, accept;
   logic [29:0] sel_m;
   logic        sel_neg;

   assign accept    = start && (state_ff == otn_pkg::ST_IDLE);
   assign busy      = (state_ff != otn_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (accept && req_word.action == otn_pkg::ActStore &&
          32'(req_word.point_index) < 32'(otn_pkg::PointSlots)) begin
         mem_x[otn_pkg::AddrBits'(req_word.point_index)] <= req_word.pos_x;
         mem_y[otn_pkg::AddrBits'(req_word.point_index)] <= req_word.pos_y;
         mem_z[otn_pkg::AddrBits'(req_word.point_index)] <= req_word.pos_z;
         mem_n[otn_pkg::AddrBits'(req_word.point_index)] <=
            {req_word.norm_z, req_word.norm_y, req_word.norm_x};
      end
      rdx_ff   <= mem_x[otn_pkg::AddrBits'(rd_idx)];
      rdy_ff   <= mem_y[otn_pkg::AddrBits'(rd_idx)];
      rdz_ff   <= mem_z[otn_pkg::AddrBits'(rd_idx)];
      rdn_ff   <= mem_n[otn_pkg::AddrBits'(rd_idx)];
      rd_ok_ff <= 32'(rd_idx) < 32'(otn_pkg::PointSlots);
   end

   always_comb begin
      case (fc_ff)
         2'd0:    rd_idx = idx_a_ff;
         2'd1:    rd_idx = idx_b_ff;
         default: rd_idx = idx_c_ff;
      endcase
      dpos[0] = rd_ok_ff ? rdx_ff : '0;
      dpos[1] = rd_ok_ff ? rdy_ff : '0;
      dpos[2] = rd_ok_ff ? rdz_ff : '0;
      dnrm[0] = rd_ok_ff ? rdn_ff[15:0] : '0;
      dnrm[1] = rd_ok_ff ? rdn_ff[31:16] : '0;
      dnrm[2] = rd_ok_ff ? rdn_ff[47:32] : '0;
   end

   always_comb begin
      ld_a   = '0;
      ld_b   = '0;
      ld_sub = 1'b0;
      sel_m  = '0;
      unique case (state_ff)
         otn_pkg::ST_CROSS: begin
            ld_sub = prod_ff[0];
            case (prod_ff)
               3'd0: begin ld_a = 88'(e1_ff[1]); ld_b = 34'(e2_ff[2]); end
               3'd1: begin ld_a = 88'(e1_ff[2]); ld_b = 34'(e2_ff[1]); end
               3'd2: begin ld_a = 88'(e1_ff[2]); ld_b = 34'(e2_ff[0]); end
               3'd3: begin ld_a = 88'(e1_ff[0]); ld_b = 34'(e2_ff[2]); end
               3'd4: begin ld_a = 88'(e1_ff[0]); ld_b = 34'(e2_ff[1]); end
               default: begin ld_a = 88'(e1_ff[1]); ld_b = 34'(e2_ff[0]); end
            endcase
         end
         otn_pkg::ST_DOT: begin
            case (prod_ff)
               3'd0:    begin ld_a = 88'(c_ff[0]); ld_b = 34'(ns_ff[0]); end
               3'd1:    begin ld_a = 88'(c_ff[1]); ld_b = 34'(ns_ff[1]); end
               default: begin ld_a = 88'(c_ff[2]); ld_b = 34'(ns_ff[2]); end
            endcase
         end
         otn_pkg::ST_SQUARE, otn_pkg::ST_DIVIDE: begin
            case (prod_ff)
               3'd0:    sel_m = mg_ff[0][29:0];
               3'd1:    sel_m = mg_ff[1][29:0];
               default: sel_m = mg_ff[2][29:0];
            endcase
            ld_a = 88'(sel_m);
            ld_b = 34'(sel_m);
         end
         default: ld_a = '0;
      endcase
      ld_neg  = ld_b[33] ^ ld_sub;
      ld_bmag = ld_b[33] ? -ld_b : ld_b;
      case (prod_ff)
         3'd0:    sel_neg = c_ff[0][67] ^ rev_ff;
         3'd1:    sel_neg = c_ff[1][67] ^ rev_ff;
         default: sel_neg = c_ff[2][67] ^ rev_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      fc_in        = fc_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      idx_c_in     = idx_c_ff;
      pa_in        = pa_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      ns_in        = ns_ff;
      acc_in       = acc_ff;
      mc_in        = mc_ff;
      mp_in        = mp_ff;
      dig_in       = dig_ff;
      prod_in      = prod_ff;
      c_in         = c_ff;
      mg_in        = mg_ff;
      rev_in       = rev_ff;
      sq_s_in      = sq_s_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      ds_in        = ds_ff;
      q_in         = q_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      acc_sum      = acc_ff + mc_ff * 88'(mp_ff[3:0]);
      sq_t         = sq_r_ff + sq_bit_ff;
      face_val     = '0;
      any_hi   = (|mg_ff[0][66:30]) | (|mg_ff[1][66:30]) | (|mg_ff[2][66:30]);
      any_29   = mg_ff[0][29] | mg_ff[1][29] | mg_ff[2][29];
      all_zero = (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
      unique case (state_ff)
         otn_pkg::ST_CROSS: dig_last = 5'd9;
         otn_pkg::ST_DOT:   dig_last = 5'd5;
         otn_pkg::ST_SQUARE: dig_last = 5'd8;
         default:           dig_last = 5'd16;
      endcase

      unique case (state_ff)
         otn_pkg::ST_IDLE: begin
            if (accept && req_word.action == otn_pkg::ActTriangle) begin
               idx_a_in = req_word.vertex_a;
               idx_b_in = req_word.vertex_b;
               idx_c_in = req_word.vertex_c;
               fc_in    = 2'd0;
               rsp_in   = '0;
               state_in = otn_pkg::ST_FETCH;
            end
         end
         otn_pkg::ST_FETCH: begin
            fc_in = fc_ff + 2'd1;
            for (int i = 0; i < 3; i++) begin
               case (fc_ff)
                  2'd1: begin
                     pa_in[i] = dpos[i];
                     ns_in[i] = 18'(dnrm[i]);
                  end
                  2'd2: begin
                     e1_in[i] = 33'(dpos[i]) - 33'(pa_ff[i]);
                     ns_in[i] = ns_ff[i] + 18'(dnrm[i]);
                  end
                  2'd3: begin
                     e2_in[i] = 33'(dpos[i]) - 33'(pa_ff[i]);
                     ns_in[i] = ns_ff[i] + 18'(dnrm[i]);
                  end
                  default: ;
               endcase
            end
            if (fc_ff == 2'd3) begin
               acc_in   = '0;
               dig_in   = '0;
               prod_in  = '0;
               state_in = otn_pkg::ST_CROSS;
            end
         end
         otn_pkg::ST_CROSS, otn_pkg::ST_DOT, otn_pkg::ST_SQUARE: begin
            if (dig_ff == '0) begin
               if (state_ff == otn_pkg::ST_DOT && prod_ff == '0 && all_zero) begin
                  rsp_in.degenerate = 1'b1;
                  rsp_valid_in      = 1'b1;
                  state_in          = otn_pkg::ST_IDLE;
               end else begin
                  mc_in  = ld_neg ? -ld_a : ld_a;
                  mp_in  = 36'(ld_bmag);
                  dig_in = 5'd1;
               end
            end else begin
               acc_in = acc_sum;
               mc_in  = {mc_ff[83:0], 4'b0};
               mp_in  = {4'b0, mp_ff[35:4]};
               dig_in = dig_ff + 5'd1;
               if (dig_ff == dig_last) begin
                  dig_in  = '0;
                  prod_in = prod_ff + 3'd1;
                  if (state_ff == otn_pkg::ST_CROSS) begin
                     if (prod_ff[0]) begin
                        acc_in = '0;
                        case (prod_ff[2:1])
                           2'd0:    c_in[0] = acc_sum[67:0];
                           2'd1:    c_in[1] = acc_sum[67:0];
                           default: c_in[2] = acc_sum[67:0];
                        endcase
                     end
                     if (prod_ff == 3'd5) begin
                        prod_in  = '0;
                        state_in = otn_pkg::ST_DOT;
                     end
                  end else if (state_ff == otn_pkg::ST_DOT) begin
                     if (prod_ff == 3'd2) begin
                        rev_in        = acc_sum[87];
                        rsp_in.reversed = acc_sum[87];
                        for (int i = 0; i < 3; i++) begin
                           mg_in[i] = c_ff[i][67] ? 67'(-c_ff[i]) : 67'(c_ff[i]);
                        end
                        state_in = otn_pkg::ST_NORM;
                     end
                  end else if (prod_ff == 3'd2) begin
                     sq_s_in   = 64'(acc_sum[61:0]);
                     sq_r_in   = '0;
                     sq_bit_in = 64'd1 << 62;
                     state_in  = otn_pkg::ST_SQRT;
                  end
               end
            end
         end
         otn_pkg::ST_NORM: begin
            if (any_hi) begin
               for (int i = 0; i < 3; i++) mg_in[i] = {1'b0, mg_ff[i][66:1]};
            end else if (!any_29) begin
               for (int i = 0; i < 3; i++) mg_in[i] = {mg_ff[i][65:0], 1'b0};
            end else begin
               acc_in   = '0;
               dig_in   = '0;
               prod_in  = '0;
               state_in = otn_pkg::ST_SQUARE;
            end
         end
         otn_pkg::ST_SQRT: begin
            if (sq_bit_ff == '0) begin
               len_in   = sq_r_ff[31:0];
               dig_in   = '0;
               prod_in  = '0;
               state_in = otn_pkg::ST_DIVIDE;
            end else begin
               if (sq_s_ff >= sq_t) begin
                  sq_s_in = sq_s_ff - sq_t;
                  sq_r_in = {1'b0, sq_r_ff[63:1]} + sq_bit_ff;
               end else begin
                  sq_r_in = {1'b0, sq_r_ff[63:1]};
               end
               sq_bit_in = {2'b0, sq_bit_ff[63:2]};
            end
         end
         otn_pkg::ST_DIVIDE: begin
            if (dig_ff == '0) begin
               rem_in = {2'b0, sel_m, 15'b0} + 47'(len_ff);
               ds_in  = 47'({len_ff, 16'b0});
               q_in   = '0;
               dig_in = 5'd1;
            end else begin
               if (rem_ff >= ds_ff) begin
                  rem_in = rem_ff - ds_ff;
                  q_in   = {q_ff[14:0], 1'b1};
               end else begin
                  q_in   = {q_ff[14:0], 1'b0};
               end
               ds_in  = {1'b0, ds_ff[46:1]};
               dig_in = dig_ff + 5'd1;
               if (dig_ff == dig_last) begin
                  dig_in   = '0;
                  prod_in  = prod_ff + 3'd1;
                  face_val = sel_neg ? -q_in : q_in;
                  case (prod_ff)
                     3'd0:    rsp_in.face_x = face_val;
                     3'd1:    rsp_in.face_y = face_val;
                     default: rsp_in.face_z = face_val;
                  endcase
                  if (prod_ff == 3'd2) begin
                     rsp_valid_in = 1'b1;
                     state_in     = otn_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = otn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= otn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fc_ff        <= '0;
         dig_ff       <= '0;
         prod_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fc_ff        <= fc_in;
         dig_ff       <= dig_in;
         prod_ff      <= prod_in;
      end
      idx_a_ff  <= idx_a_in;
      idx_b_ff  <= idx_b_in;
      idx_c_ff  <= idx_c_in;
      pa_ff     <= pa_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      ns_ff     <= ns_in;
      acc_ff    <= acc_in;
      mc_ff     <= mc_in;
      mp_ff     <= mp_in;
      c_ff      <= c_in;
      mg_ff     <= mg_in;
      rev_ff    <= rev_in;
      sq_s_ff   <= sq_s_in;
      sq_r_ff   <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      len_ff    <= len_in;
      rem_ff    <= rem_in;
      ds_ff     <= ds_in;
      q_ff      <= q_in;
      rsp_ff    <= rsp_in;
   end

endmodule
